### src/scfs_pkg.sv
// Shared types and constants for the string to CAN frame segmenter.
// No dependencies.
`default_nettype none
package scfs_pkg;

   localparam int CharW       = 8;
   localparam int SidW        = 11;
   localparam int IdWordW     = 13;
   localparam int LenW        = 4;
   localparam int WordW       = 16;
   localparam int NumWords    = 3;
   localparam int SlotW       = 2;
   localparam int ReqDataW    = 24;
   localparam int RspDataW    = 88;
   localparam int QueueDepth  = 2;

   localparam logic [LenW-1:0]  FrameLen      = 4'd8;
   localparam logic [WordW-1:0] BytesPerFrame = 16'd6;
   localparam logic [CharW-1:0] EndChar       = 8'h00;
   localparam logic [SlotW-1:0] LastSlot      = 2'd2;
   localparam logic [SlotW-1:0] FirstSlot     = 2'd0;

   typedef struct packed {
      logic [CharW-1:0] ch;
      logic [SidW-1:0]  sid;
      logic [SlotW-1:0] slot;
      logic             high;
      logic             full;
      logic             last;
   } cmd_type;

endpackage
`default_nettype wire

### src/string_to_can_frame_segmenter.sv
// String to CAN frame segmenter, top level.
// Depends on scfs_pkg, scfs_front, scfs_queue and scfs_back.
//
// Usage: characters of zero-terminated strings enter on the req_ stream, one per
// transfer, each with the 11-bit identifier for its frames. Bytes are packed low
// byte first into data words 1 to 3; word 0 carries the byte offset of the frame
// within its string. A frame leaves on the rsp_ stream after six bytes or after
// the zero byte, which is packed too and marked by rsp_tlast.
// Path: the byte that completes a frame passes through the queue, then the output
// register, before the frame can transfer on the rsp_ stream.
// Throughput: one character per cycle unless a completed frame meets a full output
// register and rsp_tready low; a frame waits there as characters go through the queue.
// Stall: with rsp_tready low the output register holds its frame; the command
// queue fills and req_tready drops once it holds QUEUE_DEPTH commands.
// Reset: position returns to word 1 low byte, offset to 0, data words to zero,
// the queue and the output register empty.
`default_nettype none
module string_to_can_frame_segmenter #(
   parameter int QUEUE_DEPTH = scfs_pkg::QueueDepth
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // character [7:0], identifier [18:8], zero [23:19]
   input  wire [scfs_pkg::ReqDataW-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // id_word [12:0], length_bytes [16:13], offset_word [32:17],
   // data_word_one [48:33], data_word_two [64:49], data_word_three [80:65],
   // zero [87:81]
   output logic [scfs_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tlast
);
   import scfs_pkg::*;

   cmd_type            front_cmd;
   cmd_type            back_cmd;
   logic               accept;
   logic               q_not_empty;
   logic               q_pop;
   logic [IdWordW-1:0] id_word;
   logic [LenW-1:0]    length_bytes;
   logic [WordW-1:0]   offset_word;
   logic [WordW-1:0]   data_word_one;
   logic [WordW-1:0]   data_word_two;
   logic [WordW-1:0]   data_word_three;

   assign accept = req_tvalid && req_tready;

   scfs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .ch     (req_tdata[CharW-1:0]),
      .sid    (req_tdata[CharW+SidW-1:CharW]),
      .accept (accept),
      .cmd    (front_cmd)
   );

   scfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cmd  (front_cmd),
      .push      (accept),
      .not_full  (req_tready),
      .pop_cmd   (back_cmd),
      .not_empty (q_not_empty),
      .pop       (q_pop)
   );

   scfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (back_cmd),
      .cmd_valid       (q_not_empty),
      .cmd_pop         (q_pop),
      .frame_valid     (rsp_tvalid),
      .frame_ready     (rsp_tready),
      .id_word         (id_word),
      .length_bytes    (length_bytes),
      .offset_word     (offset_word),
      .data_word_one   (data_word_one),
      .data_word_two   (data_word_two),
      .data_word_three (data_word_three),
      .last_of_string  (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, data_word_three, data_word_two, data_word_one,
                       offset_word, length_bytes, id_word};

endmodule
`default_nettype wire

### src/scfs_front.sv
// Front end: tracks byte position and classifies each character into a command.
// Depends on scfs_pkg.
`default_nettype none
module scfs_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [scfs_pkg::CharW-1:0]  ch,
   input  wire [scfs_pkg::SidW-1:0]   sid,
   input  wire                        accept,
   output scfs_pkg::cmd_type          cmd
);
   import scfs_pkg::*;

   logic             high_ff, high_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic             full;
   logic             last;

   assign last = (ch == EndChar);
   assign full = high_ff && (slot_ff == LastSlot);

   always_comb begin
      high_in = high_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (last) begin
            high_in = 1'b0;
            slot_in = FirstSlot;
         end else if (!high_ff) begin
            high_in = 1'b1;
         end else begin
            high_in = 1'b0;
            slot_in = full ? FirstSlot : slot_ff + SlotW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff <= 1'b0;
         slot_ff <= FirstSlot;
      end else begin
         high_ff <= high_in;
         slot_ff <= slot_in;
      end
   end

   assign cmd.ch   = ch;
   assign cmd.sid  = sid;
   assign cmd.slot = slot_ff;
   assign cmd.high = high_ff;
   assign cmd.full = full;
   assign cmd.last = last;

endmodule
`default_nettype wire

### src/scfs_queue.sv
// Short command queue between the front and back ends.
// Depends on scfs_pkg.
`default_nettype none
module scfs_queue #(
   parameter int DEPTH = scfs_pkg::QueueDepth
) (
   input  wire                clock,
   input  wire                reset,
   input  scfs_pkg::cmd_type  push_cmd,
   input  wire                push,
   output logic               not_full,
   output scfs_pkg::cmd_type  pop_cmd,
   output logic               not_empty,
   input  wire                pop
);
   import scfs_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type           entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign not_full  = (cnt_ff != CntW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### src/scfs_back.sv
// Back end: packs bytes into data words, keeps the offset and registers frames.
// Depends on scfs_pkg.
`default_nettype none
module scfs_back (
   input  wire                          clock,
   input  wire                          reset,
   input  scfs_pkg::cmd_type            cmd,
   input  wire                          cmd_valid,
   output logic                         cmd_pop,
   output logic                         frame_valid,
   input  wire                          frame_ready,
   output logic [scfs_pkg::IdWordW-1:0] id_word,
   output logic [scfs_pkg::LenW-1:0]    length_bytes,
   output logic [scfs_pkg::WordW-1:0]   offset_word,
   output logic [scfs_pkg::WordW-1:0]   data_word_one,
   output logic [scfs_pkg::WordW-1:0]   data_word_two,
   output logic [scfs_pkg::WordW-1:0]   data_word_three,
   output logic                         last_of_string
);
   import scfs_pkg::*;

   logic [WordW-1:0]   words_ff [NumWords];
   logic [WordW-1:0]   words_in [NumWords];
   logic [WordW-1:0]   offset_ff, offset_in;
   logic               valid_ff, valid_in;
   logic               emit;
   logic [IdWordW-1:0] id_ff;
   logic [WordW-1:0]   off_out_ff;
   logic [WordW-1:0]   d1_ff, d2_ff, d3_ff;
   logic               last_ff;

   assign emit    = cmd.full || cmd.last;
   assign cmd_pop = cmd_valid && (!emit || !valid_ff || frame_ready);

   always_comb begin
      for (int i = 0; i < NumWords; i++) begin
         words_in[i] = words_ff[i];
         if (cmd_pop && (cmd.slot == SlotW'(i))) begin
            if (cmd.high) begin
               words_in[i] = words_ff[i] | {cmd.ch, {CharW{1'b0}}};
            end else begin
               words_in[i] = {{(WordW-CharW){1'b0}}, cmd.ch};
            end
         end
      end
   end

   always_comb begin
      offset_in = offset_ff;
      valid_in  = valid_ff && !frame_ready;
      if (cmd_pop && emit) begin
         valid_in  = 1'b1;
         offset_in = cmd.last ? '0 : offset_ff + BytesPerFrame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumWords; i++) begin
            words_ff[i] <= '0;
         end
         offset_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < NumWords; i++) begin
            words_ff[i] <= words_in[i];
         end
         offset_ff <= offset_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && emit) begin
         id_ff      <= {cmd.sid, 2'b00};
         off_out_ff <= offset_ff;
         d1_ff      <= words_in[0];
         d2_ff      <= words_in[1];
         d3_ff      <= words_in[2];
         last_ff    <= cmd.last;
      end
   end

   assign frame_valid     = valid_ff;
   assign id_word         = id_ff;
   assign length_bytes    = FrameLen;
   assign offset_word     = off_out_ff;
   assign data_word_one   = d1_ff;
   assign data_word_two   = d2_ff;
   assign data_word_three = d3_ff;
   assign last_of_string  = last_ff;

endmodule
`default_nettype wire
